>>> rtl/core/usbbot_pkg.sv
package usbbot_pkg;

  // CBW signature "USBC", little-endian on the wire.
  localparam logic [31:0] CBW_MAGIC = 32'h4342_5355;

  localparam int RESPONSE_BYTES_DEF = 4096;

  localparam logic [3:0] IN_EP_RESET  = 4'd1;
  localparam logic [3:0] OUT_EP_RESET = 4'd2;

  typedef enum logic [1:0] {
    OP_OUT_PKT   = 2'd0,
    OP_IN_DONE   = 2'd1,
    OP_SCSI      = 2'd2,
    OP_BUS_RESET = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SCSI_OK        = 2'd0,
    SCSI_CONTINUE  = 2'd1,
    SCSI_NOT_READY = 2'd2,
    SCSI_OTHER_ERR = 2'd3
  } scsi_res_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_IN_DATA = 2'd1,
    ACT_ARM_OUT = 2'd2,
    ACT_CSW     = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    PH_READY          = 3'd0,
    PH_GOT_CMD        = 3'd1,
    PH_WAIT_IN_READY  = 3'd2,
    PH_WAIT_IN_DONE   = 3'd3,
    PH_WAIT_OUT       = 3'd4,
    PH_WAIT_OUT_PROC  = 3'd5,
    PH_TRIGGER_STATUS = 3'd6,
    PH_WAIT_STATUS    = 3'd7
  } phase_t;

  typedef enum logic {
    REG_IN_EP  = 1'b0,
    REG_OUT_EP = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] sig_word;
    logic [31:0] cbw_tag;
    logic        dir_in;
    logic        more_out_data;
    logic        in_error;
    scsi_res_t   scsi_result;
    logic [12:0] response_length;
    logic        scsi_attention;
  } in_item_t;

  typedef struct packed {
    act_t        action;
    logic [3:0]  endpoint;
    logic [12:0] data_length;
    logic [31:0] csw_tag;
    logic        csw_failed;
    logic        busy_res;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [3:0] in_ep;
    logic [3:0] out_ep;
  } ep_cfg_t;

  // Results of one event: count is 0, 1 or 2, first goes out first.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } res_pair_t;

endpackage

>>> rtl/core/usb_bulk_only_transport_fsm.sv
// Device-side Bulk-Only Transport sequencer for USB mass storage. Each input
// transaction carries one event (bulk OUT packet, bulk IN completion, SCSI
// outcome or bus reset); each event yields zero, one or two output
// transactions (send IN data, arm the OUT endpoint, or send a CSW carrying the
// stored tag and pass/fail status), the final one marked by last. Events are
// taken one per cycle while the result buffer has space: an event is held in
// the input register, and the phase update plus the result decision happen as
// it moves into a two-entry result buffer. Results leave at one per cycle while
// out_ready is high, so a two-result event holds the input side until its
// second result is leaving, and a stalled output holds the input side whenever
// the buffer holds a result. Endpoint numbers must be written through the cfg
// port while the block is idle (not enforced here); they reset to 1 (IN), 2 (OUT).
module usb_bulk_only_transport_fsm #(
  parameter int RESPONSE_BYTES = usbbot_pkg::RESPONSE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  usbbot_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output usbbot_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  usbbot_pkg::cfg_reg_t  cfg_index,
  input  logic [3:0]            cfg_wdata
);

  // Endpoint configuration registers.
  logic [3:0]            in_ep_r, in_ep_nxt;
  logic [3:0]            out_ep_r, out_ep_nxt;
  usbbot_pkg::ep_cfg_t   ep_cfg;

  logic                  item_valid;
  usbbot_pkg::in_item_t  item;
  logic                  commit;
  logic                  space;
  usbbot_pkg::res_pair_t pair;

  always_comb begin
    in_ep_nxt  = in_ep_r;
    out_ep_nxt = out_ep_r;
    if (cfg_we) begin
      unique case (cfg_index)
        usbbot_pkg::REG_IN_EP:  in_ep_nxt  = cfg_wdata;
        usbbot_pkg::REG_OUT_EP: out_ep_nxt = cfg_wdata;
        default:                in_ep_nxt  = in_ep_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ep_r  <= usbbot_pkg::IN_EP_RESET;
      out_ep_r <= usbbot_pkg::OUT_EP_RESET;
    end else begin
      in_ep_r  <= in_ep_nxt;
      out_ep_r <= out_ep_nxt;
    end
  end

  assign ep_cfg.in_ep  = in_ep_r;
  assign ep_cfg.out_ep = out_ep_r;

  // The input register releases its event in the cycle the sequencer commits it.
  usbbot_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .pop        (commit),
    .item_valid (item_valid),
    .item       (item)
  );

  // The protocol phase and held tag advance only when the event's results
  // can be stored, so no result is ever dropped.
  usbbot_seq #(
    .RESPONSE_BYTES (RESPONSE_BYTES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .ep_cfg     (ep_cfg),
    .space      (space),
    .commit     (commit),
    .pair       (pair)
  );

  usbbot_res_buf u_res_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (commit),
    .pair      (pair),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/usbbot_in_stage.sv
module usbbot_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  usbbot_pkg::in_item_t in_data,
  input  logic                pop,
  output logic                item_valid,
  output usbbot_pkg::in_item_t item
);

  logic                 valid_r;
  logic                 valid_nxt;
  usbbot_pkg::in_item_t item_r;

  assign in_ready   = !valid_r || pop;
  assign item_valid = valid_r;
  assign item       = item_r;

  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (pop ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

>>> rtl/core/usbbot_seq.sv
module usbbot_seq #(
  parameter int RESPONSE_BYTES = usbbot_pkg::RESPONSE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  usbbot_pkg::in_item_t item,
  input  usbbot_pkg::ep_cfg_t  ep_cfg,
  input  logic                 space,
  output logic                 commit,
  output usbbot_pkg::res_pair_t pair
);

  localparam int          LEN_CAP_INT = (RESPONSE_BYTES > 8191) ? 8191 : RESPONSE_BYTES;
  localparam logic [12:0] LEN_CAP     = 13'(LEN_CAP_INT);

  usbbot_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]        held_tag_r, held_tag_nxt;
  usbbot_pkg::act_t   act0, act1;
  logic [1:0]         res_n;
  logic               sig_ok;
  logic [12:0]        len_sat;
  logic               busy;

  assign commit  = item_valid && space;
  assign sig_ok  = (item.sig_word == usbbot_pkg::CBW_MAGIC);
  assign len_sat = (item.response_length > LEN_CAP) ? LEN_CAP : item.response_length;

  // Next phase and held tag.
  always_comb begin
    phase_nxt    = phase_r;
    held_tag_nxt = held_tag_r;
    unique case (item.operation)
      usbbot_pkg::OP_OUT_PKT: begin
        unique case (phase_r)
          usbbot_pkg::PH_READY: begin
            if (sig_ok) begin
              held_tag_nxt = item.cbw_tag;
              if (item.dir_in) begin
                phase_nxt = usbbot_pkg::PH_WAIT_IN_READY;
              end else if (item.more_out_data) begin
                phase_nxt = usbbot_pkg::PH_WAIT_OUT;
              end else begin
                phase_nxt = usbbot_pkg::PH_WAIT_STATUS;
              end
            end
          end
          usbbot_pkg::PH_WAIT_OUT:       phase_nxt = usbbot_pkg::PH_WAIT_OUT_PROC;
          usbbot_pkg::PH_TRIGGER_STATUS: phase_nxt = usbbot_pkg::PH_WAIT_STATUS;
          default:                       phase_nxt = phase_r;
        endcase
      end
      usbbot_pkg::OP_IN_DONE: begin
        if (item.in_error) begin
          phase_nxt = usbbot_pkg::PH_READY;
        end else begin
          unique case (phase_r)
            usbbot_pkg::PH_TRIGGER_STATUS: phase_nxt = usbbot_pkg::PH_WAIT_STATUS;
            usbbot_pkg::PH_WAIT_IN_DONE:   phase_nxt = usbbot_pkg::PH_WAIT_IN_READY;
            usbbot_pkg::PH_WAIT_STATUS:    phase_nxt = usbbot_pkg::PH_READY;
            default:                       phase_nxt = phase_r;
          endcase
        end
      end
      usbbot_pkg::OP_SCSI: begin
        unique case (phase_r)
          usbbot_pkg::PH_WAIT_IN_READY: begin
            phase_nxt = (item.scsi_result == usbbot_pkg::SCSI_CONTINUE) ?
                        usbbot_pkg::PH_WAIT_IN_DONE : usbbot_pkg::PH_TRIGGER_STATUS;
          end
          usbbot_pkg::PH_WAIT_OUT_PROC: begin
            unique case (item.scsi_result)
              usbbot_pkg::SCSI_CONTINUE:  phase_nxt = usbbot_pkg::PH_WAIT_OUT;
              usbbot_pkg::SCSI_OTHER_ERR: phase_nxt = usbbot_pkg::PH_TRIGGER_STATUS;
              default:                    phase_nxt = usbbot_pkg::PH_WAIT_STATUS;
            endcase
          end
          default: phase_nxt = phase_r;
        endcase
      end
      default: begin
        phase_nxt    = usbbot_pkg::PH_READY;
        held_tag_nxt = '0;
      end
    endcase
  end

  // Actions caused by the event, in the order they go out.
  always_comb begin
    res_n = 2'd0;
    act0  = usbbot_pkg::ACT_NONE;
    act1  = usbbot_pkg::ACT_NONE;
    unique case (item.operation)
      usbbot_pkg::OP_OUT_PKT: begin
        unique case (phase_r)
          usbbot_pkg::PH_READY: begin
            if (sig_ok) begin
              if (item.dir_in || item.more_out_data) begin
                res_n = 2'd1;
                act0  = usbbot_pkg::ACT_ARM_OUT;
              end else begin
                res_n = 2'd2;
                act0  = usbbot_pkg::ACT_CSW;
                act1  = usbbot_pkg::ACT_ARM_OUT;
              end
            end
          end
          usbbot_pkg::PH_WAIT_OUT: res_n = 2'd0;
          usbbot_pkg::PH_TRIGGER_STATUS: begin
            res_n = 2'd2;
            act0  = usbbot_pkg::ACT_CSW;
            act1  = usbbot_pkg::ACT_ARM_OUT;
          end
          default: begin
            res_n = 2'd1;
            act0  = usbbot_pkg::ACT_ARM_OUT;
          end
        endcase
      end
      usbbot_pkg::OP_IN_DONE: begin
        if (!item.in_error && phase_r == usbbot_pkg::PH_TRIGGER_STATUS) begin
          res_n = 2'd1;
          act0  = usbbot_pkg::ACT_CSW;
        end
      end
      usbbot_pkg::OP_SCSI: begin
        if (item.scsi_result != usbbot_pkg::SCSI_OTHER_ERR) begin
          if (phase_r == usbbot_pkg::PH_WAIT_IN_READY) begin
            res_n = 2'd1;
            act0  = usbbot_pkg::ACT_IN_DATA;
          end else if (phase_r == usbbot_pkg::PH_WAIT_OUT_PROC) begin
            act0 = usbbot_pkg::ACT_ARM_OUT;
            if (item.scsi_result == usbbot_pkg::SCSI_CONTINUE) begin
              res_n = 2'd1;
            end else begin
              res_n = 2'd2;
              act1  = usbbot_pkg::ACT_CSW;
            end
          end
        end
      end
      default: res_n = 2'd0;
    endcase
  end

  assign busy = (phase_nxt != usbbot_pkg::PH_READY);

  function automatic usbbot_pkg::out_item_t make_res(usbbot_pkg::act_t act, logic lst);
    usbbot_pkg::out_item_t r;
    r.action      = act;
    r.endpoint    = (act == usbbot_pkg::ACT_ARM_OUT) ? ep_cfg.out_ep : ep_cfg.in_ep;
    r.data_length = (act == usbbot_pkg::ACT_IN_DATA) ? len_sat : 13'd0;
    r.csw_tag     = (act == usbbot_pkg::ACT_CSW) ? held_tag_nxt : 32'd0;
    r.csw_failed  = (act == usbbot_pkg::ACT_CSW) ? item.scsi_attention : 1'b0;
    r.busy_res    = busy;
    r.last        = lst;
    return r;
  endfunction

  always_comb begin
    pair.count  = res_n;
    pair.first  = make_res(act0, (res_n == 2'd1));
    pair.second = make_res(act1, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= usbbot_pkg::PH_READY;
      held_tag_r <= '0;
    end else if (commit) begin
      phase_r    <= phase_nxt;
      held_tag_r <= held_tag_nxt;
    end
  end

`ifndef SYNTHESIS
  a_bus_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    commit && item.operation == usbbot_pkg::OP_BUS_RESET
    |=> phase_r == usbbot_pkg::PH_READY && held_tag_r == 32'd0)
    else $error("bus reset did not return the sequencer to ready");
  a_no_got_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != usbbot_pkg::PH_GOT_CMD)
    else $error("sequencer entered the unused got-command phase");
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    commit && pair.count == 2'd2 |-> !pair.first.last && pair.second.last)
    else $error("two-result event has wrong last marks");
`endif

endmodule

>>> rtl/core/usbbot_res_buf.sv
module usbbot_res_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  usbbot_pkg::res_pair_t pair,
  output logic                  space,
  output logic                  out_valid,
  input  logic                  out_ready,
  output usbbot_pkg::out_item_t out_data
);

  logic [1:0]            cnt_r, cnt_nxt;
  usbbot_pkg::out_item_t slot_r [2];
  logic                  take;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot_r[0];
  assign take      = out_valid && out_ready;
  // A new pair may land once the buffer is empty or drains this cycle.
  assign space     = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);

  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = pair.count;
    end else if (take) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r[0] <= pair.first;
      slot_r[1] <= pair.second;
    end else if (take) begin
      slot_r[0] <= slot_r[1];
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");
  a_load_space: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> space)
    else $error("results loaded into a full buffer");
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd1 |-> slot_r[0].last)
    else $error("final buffered result lacks its last mark");
`endif

endmodule
